// ===== sv/rdem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdem_pkg: shared types and constants for the region dwell event monitor
// Field widths, mode and event codes, register indexes, pipeline word formats
// and the constants of the divide-by-1000 pipeline.
// ----------------------------------------------------------------------------
package rdem_pkg;

    localparam int COORD_BITS   = 12;
    localparam int NUM_CLASSES  = 64;
    localparam int CLASS_BITS   = 6;
    localparam int TIME_BITS    = 64;
    localparam int DWELL_BITS   = 55;
    localparam int STAY_BITS    = 16;
    localparam int STAY_US_BITS = 36;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam longint unsigned US_PER_SEC = 64'd1000000;

    // dwell_ms = elapsed / 1000 = (elapsed >> 3) / 125, the odd part taken
    // one 16-bit chunk per stage, each chunk divided by a reciprocal multiply
    localparam int DIV_SHIFT   = 3;
    localparam int DIV_ODD     = 125;
    localparam int REM_BITS    = 7;
    localparam int DIV_CHUNK   = 16;
    localparam int DIV_STAGES  = TIME_BITS / DIV_CHUNK;
    localparam int PART_BITS   = REM_BITS + DIV_CHUNK;
    localparam int RECIP_SHIFT = 30;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
    localparam int RECIP_BITS  = 24;
    localparam int PROD_BITS   = PART_BITS + RECIP_BITS;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_INSIDE  = 2'd1,
        MODE_ALARMED = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        EV_INTRUDE = 2'd0,
        EV_ALARM   = 2'd1,
        EV_LEAVE   = 2'd2,
        EV_RESOLVE = 2'd3
    } t_ev_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_X_MIN      = 3'd0,
        CFG_Y_MIN      = 3'd1,
        CFG_X_MAX      = 3'd2,
        CFG_Y_MAX      = 3'd3,
        CFG_STAY_SEC   = 3'd4,
        CFG_WATCH_MASK = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                  has_object;
        logic                  last_of_frame;
        logic [CLASS_BITS-1:0] class_id;
        logic [COORD_BITS-1:0] foot_x;
        logic [COORD_BITS-1:0] foot_y;
        logic [TIME_BITS-1:0]  frame_time_us;
    } t_item;

    // event word as it travels down the divider pipeline
    typedef struct packed {
        t_ev_kind              kind;
        logic [CLASS_BITS-1:0] cls;
        logic [TIME_BITS-1:0]  start;
        logic [TIME_BITS-1:0]  num;
        logic [TIME_BITS-1:0]  quo;
        logic [REM_BITS-1:0]   rem;
    } t_evt;

    typedef struct packed {
        t_mode mode;
        logic  frame_hit;
    } t_mon_status;

endpackage

// ===== sv/rdem_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdem_div_step: one stage of the divide-by-125 pipeline
// Takes the next 16-bit chunk of the dividend, divides remainder and chunk by
// a reciprocal multiply, shifts the quotient chunk in and holds the word.
// ----------------------------------------------------------------------------
module rdem_div_step import rdem_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_evt i_evt,
    output logic o_rdy,
    output logic o_vld,
    output t_evt o_evt,
    input  logic i_rdy_dn
);

    logic                  r_vld;
    t_evt                  r_evt;
    t_evt                  n_evt;
    logic [PART_BITS-1:0]  part;
    logic [PROD_BITS-1:0]  prod;
    logic [DIV_CHUNK-1:0]  q;
    logic [PART_BITS-1:0]  q_mul;
    logic [PART_BITS-1:0]  part_rem;

    assign o_rdy = !r_vld || i_rdy_dn;

    always_comb begin
        part = {i_evt.rem, i_evt.num[TIME_BITS-1 -: DIV_CHUNK]};
        prod = PROD_BITS'(part) * PROD_BITS'(DIV_RECIP);
        q    = prod[RECIP_SHIFT +: DIV_CHUNK];
        // q * 125 as 128q - 2q - q
        q_mul = (PART_BITS'(q) << 7) - (PART_BITS'(q) << 1) - PART_BITS'(q);
        part_rem = part - q_mul;

        n_evt      = i_evt;
        n_evt.num  = i_evt.num << DIV_CHUNK;
        n_evt.quo  = {i_evt.quo[TIME_BITS-DIV_CHUNK-1:0], q};
        n_evt.rem  = part_rem[REM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_evt <= n_evt;
        end
    end

    assign o_vld = r_vld;
    assign o_evt = r_evt;

endmodule

// ===== sv/rdem_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdem_front: configuration, frame hit tracking and dwell state machine
// Registers the input word, tests it against the region and watch mask,
// runs the idle/inside/alarmed machine at frame end and loads an event word.
// ----------------------------------------------------------------------------
module rdem_front import rdem_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_item                    i_item,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output logic                     o_ev_vld,
    output t_evt                     o_ev,
    input  logic                     i_ev_rdy,
    output t_mon_status              o_status
);

    logic [COORD_BITS-1:0]   r_x_min, r_y_min, r_x_max, r_y_max;
    logic [STAY_US_BITS-1:0] r_stay_us;
    logic [NUM_CLASSES-1:0]  r_watch_mask;

    t_mode                   r_mode, n_mode;
    logic [TIME_BITS-1:0]    r_entry_time;
    logic [CLASS_BITS-1:0]   r_episode_class;
    logic                    r_frame_hit;
    logic [CLASS_BITS-1:0]   r_frame_class;

    logic                    r_in_vld;
    t_item                   r_in;
    logic                    r_ev_vld;
    t_evt                    r_ev;

    logic                    ev_rdy_in, consume, in_rdy;
    logic                    watched, in_roi, hit_now, hit;
    logic [CLASS_BITS-1:0]   hit_cls;
    logic [TIME_BITS-1:0]    elapsed;
    logic                    over;
    logic                    ev_fire;
    t_ev_kind                ev_kind;
    logic [CLASS_BITS-1:0]   ev_cls;
    logic [TIME_BITS-1:0]    ev_start;
    logic [TIME_BITS-1:0]    ev_num;

    assign ev_rdy_in  = !r_ev_vld || i_ev_rdy;
    assign consume    = r_in_vld && ev_rdy_in;
    assign in_rdy     = !r_in_vld || consume;
    assign o_in_stall = !in_rdy;

    assign watched = ({1'b0, r_in.class_id} < (CLASS_BITS+1)'(NUM_CLASSES))
                     && r_watch_mask[r_in.class_id];
    assign in_roi  = (r_in.foot_x >= r_x_min) && (r_in.foot_x < r_x_max)
                     && (r_in.foot_y >= r_y_min) && (r_in.foot_y < r_y_max);
    assign hit_now = r_in.has_object && watched && in_roi;
    assign hit     = r_frame_hit || hit_now;
    assign hit_cls = r_frame_hit ? r_frame_class : r_in.class_id;

    assign elapsed = r_in.frame_time_us - r_entry_time;
    assign over    = elapsed >= TIME_BITS'(r_stay_us);

    // next state
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_IDLE: begin
                if (r_in.last_of_frame && hit) n_mode = MODE_INSIDE;
            end
            MODE_INSIDE: begin
                if (r_in.last_of_frame) begin
                    if (!hit) n_mode = MODE_IDLE;
                    else if (over) n_mode = MODE_ALARMED;
                end
            end
            MODE_ALARMED: begin
                if (r_in.last_of_frame && !hit) n_mode = MODE_IDLE;
            end
            default: n_mode = MODE_IDLE;
        endcase
    end

    // event word
    always_comb begin
        ev_fire  = 1'b0;
        ev_kind  = EV_INTRUDE;
        ev_cls   = r_episode_class;
        ev_start = r_entry_time;
        ev_num   = elapsed >> DIV_SHIFT;
        unique case (r_mode)
            MODE_IDLE: begin
                if (r_in.last_of_frame && hit) begin
                    ev_fire  = 1'b1;
                    ev_kind  = EV_INTRUDE;
                    ev_cls   = hit_cls;
                    ev_start = r_in.frame_time_us;
                    ev_num   = '0;
                end
            end
            MODE_INSIDE: begin
                if (r_in.last_of_frame) begin
                    if (!hit) begin
                        ev_fire = 1'b1;
                        ev_kind = EV_LEAVE;
                    end else if (over) begin
                        ev_fire = 1'b1;
                        ev_kind = EV_ALARM;
                    end
                end
            end
            MODE_ALARMED: begin
                if (r_in.last_of_frame && !hit) begin
                    ev_fire = 1'b1;
                    ev_kind = EV_RESOLVE;
                end
            end
            default: ev_fire = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min         <= '0;
            r_y_min         <= '0;
            r_x_max         <= '0;
            r_y_max         <= '0;
            r_stay_us       <= '0;
            r_watch_mask    <= '0;
            r_mode          <= MODE_IDLE;
            r_entry_time    <= '0;
            r_episode_class <= '0;
            r_frame_hit     <= 1'b0;
            r_frame_class   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_X_MIN:      r_x_min <= i_cfg_wdata[COORD_BITS-1:0];
                    CFG_Y_MIN:      r_y_min <= i_cfg_wdata[COORD_BITS-1:0];
                    CFG_X_MAX:      r_x_max <= i_cfg_wdata[COORD_BITS-1:0];
                    CFG_Y_MAX:      r_y_max <= i_cfg_wdata[COORD_BITS-1:0];
                    CFG_STAY_SEC:   r_stay_us <= STAY_US_BITS'(i_cfg_wdata[STAY_BITS-1:0])
                                                 * STAY_US_BITS'(US_PER_SEC);
                    CFG_WATCH_MASK: r_watch_mask <= i_cfg_wdata[NUM_CLASSES-1:0];
                    default: ;
                endcase
                // a valid register write drops any open episode
                if (i_cfg_index <= CFG_WATCH_MASK) begin
                    r_mode          <= MODE_IDLE;
                    r_entry_time    <= '0;
                    r_episode_class <= '0;
                end
            end else if (consume) begin
                r_mode <= n_mode;
                if (r_mode == MODE_IDLE && n_mode == MODE_INSIDE) begin
                    r_entry_time    <= r_in.frame_time_us;
                    r_episode_class <= hit_cls;
                end
            end
            if (consume) begin
                if (r_in.last_of_frame) begin
                    r_frame_hit   <= 1'b0;
                    r_frame_class <= '0;
                end else if (hit_now && !r_frame_hit) begin
                    r_frame_hit   <= 1'b1;
                    r_frame_class <= r_in.class_id;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_ev_vld <= 1'b0;
        end else begin
            if (in_rdy) r_in_vld <= i_in_valid;
            if (ev_rdy_in) r_ev_vld <= consume && ev_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy && i_in_valid) begin
            r_in <= i_item;
        end
        if (ev_rdy_in && consume && ev_fire) begin
            r_ev.kind  <= ev_kind;
            r_ev.cls   <= ev_cls;
            r_ev.start <= ev_start;
            r_ev.num   <= ev_num;
            r_ev.quo   <= '0;
            r_ev.rem   <= '0;
        end
    end

    assign o_ev_vld           = r_ev_vld;
    assign o_ev               = r_ev;
    assign o_status.mode      = r_mode;
    assign o_status.frame_hit = r_frame_hit;

endmodule

// ===== sv/roi_dwell_event_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_dwell_event_monitor: region-of-interest dwell event monitor
// Watches a rectangle for detections of selected classes and reports
// intrude, alarm, leave and resolve events with start time and dwell.
// ----------------------------------------------------------------------------
// One detection word (or empty-frame marker) is accepted every clock cycle
// unless o_in_stall is high, and at most one event word comes out per
// accepted word. A frame-end word's event passes one input register, one
// event register where the dwell state machine decides, then four divider
// stages that turn the elapsed microseconds into milliseconds, sixteen
// dividend bits per stage. Stall propagates back through the stages only as
// far as they are full, so the input keeps flowing while an event waits at
// the output. Region edges: minimum inclusive, maximum exclusive. Any write
// to a real register (index 0 to 5) returns the monitor to idle but keeps
// the current frame's hit; write registers only while no word is in flight.
// ----------------------------------------------------------------------------
module roi_dwell_event_monitor import rdem_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // detection words
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_has_object,
    input  logic                     i_last_of_frame,
    input  logic [CLASS_BITS-1:0]    i_class_id,
    input  logic [COORD_BITS-1:0]    i_foot_x,
    input  logic [COORD_BITS-1:0]    i_foot_y,
    input  logic [TIME_BITS-1:0]     i_frame_time_us,
    // event words
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_event_kind,
    output logic [CLASS_BITS-1:0]    o_event_class,
    output logic [TIME_BITS-1:0]     o_start_time_us,
    output logic [DWELL_BITS-1:0]    o_dwell_ms,
    // register writes
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    t_item       item;
    t_mon_status status;

    // stage k feeds divider stage k; the last entry is the output register
    logic        s_vld [0:DIV_STAGES];
    logic        s_rdy [0:DIV_STAGES];
    t_evt        s_evt [0:DIV_STAGES];

    assign item.has_object    = i_has_object;
    assign item.last_of_frame = i_last_of_frame;
    assign item.class_id      = i_class_id;
    assign item.foot_x        = i_foot_x;
    assign item.foot_y        = i_foot_y;
    assign item.frame_time_us = i_frame_time_us;

    // hit tracking, dwell state machine and event register
    rdem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ev_vld    (s_vld[0]),
        .o_ev        (s_evt[0]),
        .i_ev_rdy    (s_rdy[0]),
        .o_status    (status)
    );

    // elapsed / 1000, one 16-bit chunk per stage, most significant first
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        rdem_div_step u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_vld    (s_vld[k]),
            .i_evt    (s_evt[k]),
            .o_rdy    (s_rdy[k]),
            .o_vld    (s_vld[k+1]),
            .o_evt    (s_evt[k+1]),
            .i_rdy_dn (s_rdy[k+1])
        );
    end

    assign s_rdy[DIV_STAGES] = !i_out_stall;

    assign o_out_valid     = s_vld[DIV_STAGES];
    assign o_event_kind    = s_evt[DIV_STAGES].kind;
    assign o_event_class   = s_evt[DIV_STAGES].cls;
    assign o_start_time_us = s_evt[DIV_STAGES].start;
    assign o_dwell_ms      = s_evt[DIV_STAGES].quo[DWELL_BITS-1:0];

`ifndef ASSERT_OFF
    // intrude carries no dwell: its zero dividend must come out as zero
    a_intrude_zero_dwell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == EV_INTRUDE) |-> (o_dwell_ms == '0))
        else $error("intrude event with nonzero dwell");

    // alarm is only reached from inside, never straight from idle
    a_no_idle_to_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.mode == MODE_ALARMED) |-> ($past(status.mode) != MODE_IDLE))
        else $error("monitor jumped from idle to alarmed");

    // the quotient of a 64-bit value by 1000 never needs more than 55 bits
    a_dwell_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (s_evt[DIV_STAGES].quo[TIME_BITS-1:DWELL_BITS] == '0))
        else $error("dwell quotient overflowed its field");
`endif

endmodule

// ===== bench/roi_dwell_event_monitor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_dwell_event_monitor_test: self-checking bench for the region dwell monitor
// Feeds detection words and frame markers through the valid/stall input,
// predicts every intrude, alarm, leave and resolve event in a scoreboard, and
// checks each event word in order. A directed opening covers the rectangle
// edges, unwatched classes, all four events, time wrap and register writes.
// Random phases follow under many register settings, with random input gaps
// and output stalls.
// ----------------------------------------------------------------------------
module roi_dwell_event_monitor_test;
    import rdem_pkg::*;

    localparam longint unsigned US_PER_MS = 64'd1000;
    localparam int WORD_TARGET   = 800;
    localparam int SETTLE_CYCLES = 12;   // pipeline is six deep; leave margin
    // indexes past the register list; the block must ignore writes to them
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [TIME_BITS-1:0]    TIME_TOP     = '1;

    typedef struct packed {
        t_ev_kind               kind;
        logic [CLASS_BITS-1:0]  cls;
        logic [TIME_BITS-1:0]   start;
        logic [DWELL_BITS-1:0]  dwell;
    } t_dwell_event;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the monitor state per accepted word and queues the
    // events it should produce; event words are checked against that queue.
    // ------------------------------------------------------------------------
    class dwell_scoreboard;
        logic [COORD_BITS-1:0] x_lo, y_lo, x_hi, y_hi;
        logic [STAY_BITS-1:0]  stay_sec;
        logic [63:0]           watched;
        t_mode                 mode;
        logic [TIME_BITS-1:0]  entry_us;
        logic [CLASS_BITS-1:0] episode_cls;
        logic                  frame_hit;
        logic [CLASS_BITS-1:0] frame_cls;
        t_dwell_event          due[$];
        int                    errors;
        int                    kind_count[4];

        function new();
            x_lo = '0;
            y_lo = '0;
            x_hi = '0;
            y_hi = '0;
            stay_sec = '0;
            watched = '0;
            mode = MODE_IDLE;
            entry_us = '0;
            episode_cls = '0;
            frame_hit = 1'b0;
            frame_cls = '0;
            errors = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%0t ERROR %s", $time, msg);
        endfunction

        // Any write to a real register drops the episode; frame hit survives.
        function void note_reg_write(logic [CFG_IDX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_X_MIN:      x_lo = data[COORD_BITS-1:0];
                CFG_Y_MIN:      y_lo = data[COORD_BITS-1:0];
                CFG_X_MAX:      x_hi = data[COORD_BITS-1:0];
                CFG_Y_MAX:      y_hi = data[COORD_BITS-1:0];
                CFG_STAY_SEC:   stay_sec = data[STAY_BITS-1:0];
                CFG_WATCH_MASK: watched = data;
                default:        return;
            endcase
            mode = MODE_IDLE;
            entry_us = '0;
            episode_cls = '0;
        endfunction

        function void note_word(logic has_obj, logic last, logic [CLASS_BITS-1:0] cls,
                                logic [COORD_BITS-1:0] fx, logic [COORD_BITS-1:0] fy,
                                logic [TIME_BITS-1:0] now_us);
            logic [TIME_BITS-1:0] elapsed;
            t_dwell_event ev;
            logic emit;
            // first watched detection inside the rectangle wins the frame
            if (has_obj && !frame_hit && watched[cls] &&
                fx >= x_lo && fx < x_hi && fy >= y_lo && fy < y_hi) begin
                frame_hit = 1'b1;
                frame_cls = cls;
            end
            if (!last) return;
            elapsed = now_us - entry_us;   // wraps like the hardware subtractor
            emit = 1'b0;
            ev.kind = EV_INTRUDE;
            ev.cls = episode_cls;
            ev.start = entry_us;
            ev.dwell = DWELL_BITS'(elapsed / US_PER_MS);
            if (frame_hit) begin
                if (mode == MODE_IDLE) begin
                    mode = MODE_INSIDE;
                    entry_us = now_us;
                    episode_cls = frame_cls;
                    ev.cls = frame_cls;
                    ev.start = now_us;
                    ev.dwell = '0;
                    emit = 1'b1;
                end else if (mode == MODE_INSIDE &&
                             elapsed >= 64'(stay_sec) * US_PER_SEC) begin
                    mode = MODE_ALARMED;
                    ev.kind = EV_ALARM;
                    emit = 1'b1;
                end
            end else if (mode == MODE_INSIDE) begin
                mode = MODE_IDLE;
                ev.kind = EV_LEAVE;
                emit = 1'b1;
            end else if (mode == MODE_ALARMED) begin
                mode = MODE_IDLE;
                ev.kind = EV_RESOLVE;
                emit = 1'b1;
            end
            if (emit) due = {due, ev};
            frame_hit = 1'b0;
            frame_cls = '0;
        endfunction

        function void check_event(logic [1:0] kind, logic [CLASS_BITS-1:0] cls,
                                  logic [TIME_BITS-1:0] start,
                                  logic [DWELL_BITS-1:0] dwell);
            t_dwell_event want;
            if (due.size() == 0) begin
                flag($sformatf("unexpected event: kind %0d class %0d start %0d dwell %0d",
                               kind, cls, start, dwell));
                return;
            end
            want = due.pop_front();
            if (kind !== want.kind || cls !== want.cls ||
                start !== want.start || dwell !== want.dwell)
                flag($sformatf({"event mismatch: expected kind %0d class %0d start %0d ",
                                "dwell %0d, got kind %0d class %0d start %0d dwell %0d"},
                               want.kind, want.cls, want.start, want.dwell,
                               kind, cls, start, dwell));
            else
                kind_count[kind]++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block inputs start known; all later changes are nonblocking at posedge.
    // ------------------------------------------------------------------------
    logic                     i_clk;
    logic                     i_rst_n         = 1'b0;
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_stall;
    logic                     i_has_object    = 1'b0;
    logic                     i_last_of_frame = 1'b0;
    logic [CLASS_BITS-1:0]    i_class_id      = '0;
    logic [COORD_BITS-1:0]    i_foot_x        = '0;
    logic [COORD_BITS-1:0]    i_foot_y        = '0;
    logic [TIME_BITS-1:0]     i_frame_time_us = '0;
    logic                     o_out_valid;
    logic                     i_out_stall     = 1'b0;
    logic [1:0]               o_event_kind;
    logic [CLASS_BITS-1:0]    o_event_class;
    logic [TIME_BITS-1:0]     o_start_time_us;
    logic [DWELL_BITS-1:0]    o_dwell_ms;
    logic                     i_cfg_wr_en     = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata     = '0;

    dwell_scoreboard sb;

    // stimulus shaping: copy of the current setting, used to aim detections
    logic [COORD_BITS-1:0] roi_x0, roi_y0, roi_x1, roi_y1;
    logic [63:0]           roi_mask;
    bit                    idle_on = 1'b1;
    int                    words_sent = 0;
    int                    frames_sent = 0;
    int                    settings_used = 0;

    roi_dwell_event_monitor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_has_object    (i_has_object),
        .i_last_of_frame (i_last_of_frame),
        .i_class_id      (i_class_id),
        .i_foot_x        (i_foot_x),
        .i_foot_y        (i_foot_y),
        .i_frame_time_us (i_frame_time_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_kind    (o_event_kind),
        .o_event_class   (o_event_class),
        .o_start_time_us (o_start_time_us),
        .o_dwell_ms      (o_dwell_ms),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Gap length: mostly none, some short, a few long; none in calm phases.
    function automatic int gap_len();
        int r;
        if (!idle_on) return 0;
        r = int'($urandom_range(0, 99));
        if (r < 60) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        if (r < 98) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic [CLASS_BITS-1:0] watched_class();
        logic [CLASS_BITS-1:0] c;
        for (int k = 0; k < 8; k++) begin
            c = CLASS_BITS'($urandom);
            if (roi_mask[c]) return c;
        end
        return c;
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_in(logic [COORD_BITS-1:0] lo,
                                                     logic [COORD_BITS-1:0] hi);
        int span;
        span = int'(hi) - int'(lo);
        if (span <= 0) return COORD_BITS'($urandom);
        return lo + COORD_BITS'($urandom_range(0, span - 1));
    endfunction

    // Present one word and hold it until accepted; keep valid high when the
    // next word follows with no gap.
    task automatic send_word(input logic has_obj, input logic last,
                             input logic [CLASS_BITS-1:0] cls,
                             input logic [COORD_BITS-1:0] fx,
                             input logic [COORD_BITS-1:0] fy,
                             input logic [TIME_BITS-1:0] now_us);
        int gap;
        i_in_valid      <= 1'b1;
        i_has_object    <= has_obj;
        i_last_of_frame <= last;
        i_class_id      <= cls;
        i_foot_x        <= fx;
        i_foot_y        <= fy;
        i_frame_time_us <= now_us;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(has_obj, last, cls, fx, fy, now_us);
        if (has_obj || last) words_sent++;
        if (last) frames_sent++;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every expected event, then let the pipe empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.note_reg_write(idx, data);
    endtask

    // Write all six registers (junk in unused upper data bits), sometimes a spare index too.
    task automatic apply_setting(input logic [COORD_BITS-1:0] x0,
                                 input logic [COORD_BITS-1:0] y0,
                                 input logic [COORD_BITS-1:0] x1,
                                 input logic [COORD_BITS-1:0] y1,
                                 input logic [STAY_BITS-1:0] stay,
                                 input logic [63:0] mask);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_X_MIN,      {junk[63:COORD_BITS], x0});
        write_reg(CFG_Y_MIN,      {junk[63:COORD_BITS], y0});
        write_reg(CFG_X_MAX,      {junk[63:COORD_BITS], x1});
        write_reg(CFG_Y_MAX,      {junk[63:COORD_BITS], y1});
        write_reg(CFG_STAY_SEC,   {junk[63:STAY_BITS], stay});
        write_reg(CFG_WATCH_MASK, mask);
        if ($urandom_range(0, 2) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      {$urandom, $urandom});
        i_cfg_wr_en <= 1'b0;
        roi_x0 = x0;
        roi_y0 = y0;
        roi_x1 = x1;
        roi_y1 = y1;
        roi_mask = mask;
        settings_used++;
    endtask

    task automatic random_setting();
        logic [COORD_BITS-1:0] x0, y0, x1, y1;
        logic [STAY_BITS-1:0]  stay;
        logic [63:0]           mask;
        x0 = COORD_BITS'($urandom);
        y0 = COORD_BITS'($urandom);
        x1 = COORD_BITS'($urandom);
        y1 = COORD_BITS'($urandom);
        case ($urandom_range(0, 7))
            0: begin    // whole frame; last row and column stay outside
                x0 = '0;
                y0 = '0;
                x1 = '1;
                y1 = '1;
            end
            1: x1 = x0;  // zero width
            2: begin    // inverted
                if (x0 < x1) {x0, x1} = {x1, x0};
                if (y0 < y1) {y0, y1} = {y1, y0};
            end
            3: begin    // single pixel
                x1 = x0 + COORD_BITS'(1);
                y1 = y0 + COORD_BITS'(1);
            end
            default: begin
                if (x0 > x1) {x0, x1} = {x1, x0};
                if (y0 > y1) {y0, y1} = {y1, y0};
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1:    stay = '0;
            2, 3, 4: stay = 16'd1;
            5, 6:    stay = 16'd2;
            7:       stay = '1;
            8:       stay = STAY_BITS'($urandom_range(3, 10));
            default: stay = STAY_BITS'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       mask = '1;
            1:       mask = '0;
            2:       mask = 64'd1 << $urandom_range(0, 63);
            default: mask = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
        apply_setting(x0, y0, x1, y1, stay, mask);
    endtask

    // One frame of one to four words; the last word carries the frame end.
    // With an object present, detections aim at a watched class in the region.
    task automatic send_frame(input logic present, input logic [TIME_BITS-1:0] now_us);
        int n, r;
        logic [CLASS_BITS-1:0] cls;
        logic [COORD_BITS-1:0] fx, fy;
        logic                  last;
        n = int'($urandom_range(1, 4));
        for (int k = 0; k < n; k++) begin
            r = int'($urandom_range(0, 99));
            last = (k == n - 1);
            cls = CLASS_BITS'($urandom);
            fx = COORD_BITS'($urandom);
            fy = COORD_BITS'($urandom);
            if (r < 8) begin
                send_word(1'b0, last, cls, fx, fy, last ? now_us : {$urandom, $urandom});
            end else if (r < 18) begin
                send_word(1'b1, last, cls, fx, fy, last ? now_us : {$urandom, $urandom});
            end else begin
                if (present) begin
                    cls = watched_class();
                    fx = pick_in(roi_x0, roi_x1);
                    fy = pick_in(roi_y0, roi_y1);
                end
                send_word(1'b1, last, cls, fx, fy, now_us);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Event side: check each accepted event word, stall at random.
    // ------------------------------------------------------------------------
    initial begin : event_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_event(o_event_kind, o_event_class, o_start_time_us, o_dwell_ms);
            if (hold > 0) begin
                hold--;
            end else if (idle_on && $urandom_range(0, 99) < 25) begin
                i_out_stall <= 1'b1;
                hold = gap_len();
            end else begin
                i_out_stall <= 1'b0;
                hold = int'($urandom_range(0, 8));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed words, random phases, drain, verdict.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [TIME_BITS-1:0] t;
        logic                 present;
        int                   phase_end, base_words, r;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Region x 100..199, y 50..149, one second stay, classes 0 and 63 unwatched.
        apply_setting(12'd100, 12'd50, 12'd200, 12'd150, 16'd1, 64'h7FFF_FFFF_FFFF_FFFE);
        // marker without frame end: all other fields ignored
        send_word(1'b0, 1'b0, 6'd63, 12'hFFF, 12'hFFF, TIME_TOP);
        // point on the minimum edges counts as inside: intrude
        send_word(1'b1, 1'b1, 6'd5, 12'd100, 12'd50, 64'd1_000);
        // point on the right edge is outside: leave
        send_word(1'b1, 1'b1, 6'd5, 12'd200, 12'd100, 64'd500_000);
        // bottom edge outside, then both unwatched classes: all quiet
        send_word(1'b1, 1'b1, 6'd5, 12'd150, 12'd150, 64'd600_000);
        send_word(1'b1, 1'b1, 6'd0, 12'd150, 12'd100, 64'd700_000);
        send_word(1'b1, 1'b1, 6'd63, 12'd150, 12'd100, 64'd800_000);
        // two hits in one frame: the first one names the episode
        send_word(1'b1, 1'b0, 6'd62, 12'd199, 12'd149, 64'd2_000_000);
        send_word(1'b1, 1'b1, 6'd7, 12'd120, 12'd60, 64'd2_000_000);
        // half the stay: nothing; exactly the stay: alarm; alarmed: nothing
        send_word(1'b1, 1'b1, 6'd62, 12'd120, 12'd60, 64'd2_500_000);
        send_word(1'b1, 1'b1, 6'd62, 12'd120, 12'd60, 64'd3_000_000);
        send_word(1'b1, 1'b1, 6'd62, 12'd120, 12'd60, 64'd3_500_000);
        // empty frame ends the alarmed episode: resolve
        send_word(1'b0, 1'b1, 6'd0, 12'd0, 12'd0, 64'd4_000_000);
        // misses and markers ahead of the hit in a longer frame
        send_word(1'b1, 1'b0, 6'd3, 12'd99, 12'd60, 64'd5_000_000);
        send_word(1'b1, 1'b0, 6'd0, 12'd150, 12'd100, 64'd5_000_000);
        send_word(1'b0, 1'b0, 6'd4, 12'd150, 12'd100, 64'd5_000_000);
        send_word(1'b1, 1'b1, 6'd4, 12'd150, 12'd100, 64'd5_000_000);
        // time runs backwards: the difference wraps huge, so alarm
        send_word(1'b1, 1'b1, 6'd4, 12'd150, 12'd100, 64'd10);
        send_word(1'b1, 1'b1, 6'd4, 12'd150, 12'd100, TIME_TOP);
        send_word(1'b0, 1'b1, 6'd0, 12'd0, 12'd0, TIME_TOP);
        // episode opening near the top of the time range
        send_word(1'b1, 1'b1, 6'd9, 12'd150, 12'd100, 64'hFFFF_FFFF_FFFF_FF00);
        // writes past the register list must not drop the episode: alarm
        settle();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        i_cfg_wr_en <= 1'b0;
        send_word(1'b1, 1'b1, 6'd9, 12'd150, 12'd100, 64'd2_000_000);
        // a hit seen before a register write still counts at frame end
        send_word(1'b1, 1'b0, 6'd11, 12'd150, 12'd100, 64'd3_000_000);
        settle();
        write_reg(CFG_STAY_SEC, '0);
        i_cfg_wr_en <= 1'b0;
        send_word(1'b0, 1'b1, 6'd0, 12'd0, 12'd0, 64'd3_100_000);
        // zero stay: alarm on the very next hit, then resolve
        send_word(1'b1, 1'b1, 6'd11, 12'd150, 12'd100, 64'd3_100_000);
        send_word(1'b0, 1'b1, 6'd0, 12'd0, 12'd0, 64'd3_100_000);

        // Random phases, each under a fresh register setting.
        base_words = words_sent;
        t = {$urandom, $urandom};
        while (words_sent - base_words < WORD_TARGET) begin
            settle();
            random_setting();
            idle_on = ($urandom_range(0, 3) != 0);
            phase_end = words_sent + int'($urandom_range(60, 120));
            if ($urandom_range(0, 3) == 0) t = {$urandom, $urandom};
            present = 1'b0;
            while (words_sent < phase_end) begin
                r = int'($urandom_range(0, 99));
                if (r >= 10) begin
                    if (r < 75)
                        t = t + 64'($urandom_range(0, 400_000));
                    else if (r < 93)
                        t = t + 64'($urandom_range(400_000, 3_000_000));
                    else if (r < 97)
                        t = t - 64'($urandom_range(1, 1_000_000));
                    else
                        t = {$urandom, $urandom};
                end
                if ($urandom_range(0, 99) < 15) present = !present;
                send_frame(present, t);
            end
        end

        settle();
        $display("Covered %0d detection and frame-end words in %0d frames over %0d settings;",
                 words_sent, frames_sent, settings_used);
        $display("checked %0d intrude, %0d alarm, %0d leave and %0d resolve events.",
                 sb.kind_count[EV_INTRUDE], sb.kind_count[EV_ALARM],
                 sb.kind_count[EV_LEAVE], sb.kind_count[EV_RESOLVE]);
        if (sb.errors == 0 && sb.due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d events never seen", sb.errors, sb.due.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d events still expected", sb.due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
